// File: rtl/gct_pkg.sv
// gct_pkg: types, codes and frame constants of the general-command master.
// No dependencies; used by gct_core, gct_out and general_command_transaction.
`timescale 1ns / 1ps

package gct_pkg;

  localparam int MAX_TRIES_DEF  = 3;
  localparam int FRAME_LEN      = 16;
  localparam int FRAME_IDX_W    = $clog2(FRAME_LEN);
  localparam int ELAPSED_W      = 17;
  localparam int LIMIT_W        = 16;
  localparam int STEP_W         = 10;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 1;

  localparam logic [LIMIT_W-1:0]   TIMEOUT_LIMIT_RST = 16'd1000;
  localparam logic [STEP_W-1:0]    TICK_STEP_RST     = 10'd10;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX       = '1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_STEP     = 1'd1;

  // operation codes
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_RESP = 2'd2;

  // cause of transmission codes
  localparam logic [7:0] CAUSE_NAK    = 8'd21;
  localparam logic [7:0] CAUSE_ACK    = 8'd20;
  localparam logic [7:0] CAUSE_REMOTE = 8'd12;

  // frame bytes
  localparam logic [7:0] FR_START   = 8'h68;
  localparam logic [7:0] FR_LEN     = 8'd10;
  localparam logic [7:0] FR_CTRL    = 8'h53;
  localparam logic [7:0] FR_TYPE_ID = 8'd20;
  localparam logic [7:0] FR_VSQ     = 8'h81;
  localparam logic [7:0] FR_COT     = 8'd20;
  localparam logic [7:0] FR_END     = 8'h16;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_REPEAT = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TIMEOUT  = 3'd1,
    ERR_NAK      = 3'd2,
    ERR_VALUE    = 3'd3,
    ERR_IDENT    = 3'd4
  } err_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       is_repeat;
    logic [7:0] station_address;
    logic [7:0] function_type;
    logic [7:0] information_number;
    logic [7:0] command_value;
    logic [7:0] resp_cause;
    logic [7:0] resp_function_type;
    logic [7:0] resp_information_number;
    logic [7:0] resp_value;
    logic [7:0] resp_return_info;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_frame;
    logic       last;
    logic [1:0] mode;
    logic       ready_res;
    logic [2:0] error_code;
    logic       resend_request;
    logic [7:0] remote_value;
    logic       awaiting_response;
  } out_t;

  typedef struct packed {
    mode_t      mode;
    logic       ready;
    err_t       error;
    logic       resend;
    logic [7:0] remote;
    logic       waiting;
  } status_t;

  typedef struct packed {
    logic       fcb;
    logic [7:0] addr;
    logic [7:0] ftype;
    logic [7:0] inum;
    logic [7:0] value;
    logic [7:0] rid;
    logic [7:0] sum;
  } frame_info_t;

  // what one accepted word hands to the output stage
  typedef struct packed {
    logic        is_send;
    status_t     status;
    frame_info_t frame;
  } load_t;

  function automatic logic [7:0] ctrl_byte(input logic fcb);
    ctrl_byte = FR_CTRL | {2'b00, fcb, 5'b00000};
  endfunction

  function automatic logic [7:0] frame_byte_at(input logic [FRAME_IDX_W-1:0] idx,
                                               input frame_info_t fi);
    logic [7:0] b;
    case (idx)
      4'd0, 4'd3: b = FR_START;
      4'd1, 4'd2: b = FR_LEN;
      4'd4:       b = ctrl_byte(fi.fcb);
      4'd5, 4'd9: b = fi.addr;
      4'd6:       b = FR_TYPE_ID;
      4'd7:       b = FR_VSQ;
      4'd8:       b = FR_COT;
      4'd10:      b = fi.ftype;
      4'd11:      b = fi.inum;
      4'd12:      b = fi.value;
      4'd13:      b = fi.rid;
      4'd14:      b = fi.sum;
      4'd15:      b = FR_END;
      default:    b = FR_END;
    endcase
    frame_byte_at = b;
  endfunction

endpackage

// File: rtl/gct_core.sv
// gct_core: transaction state and its next-state logic, updated once per accepted word.
// Depends on gct_pkg.
`timescale 1ns / 1ps

module gct_core
  import gct_pkg::*;
#(
  parameter int MAX_TRIES = MAX_TRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] timeout_limit,
  input  logic [STEP_W-1:0]  tick_step,
  input  logic               accept,
  input  in_t                in_word,
  output load_t              load_word
);

  localparam int TRIES_W = $clog2(MAX_TRIES + 1);

  logic                 frame_count_bit, frame_count_bit_next;
  logic [7:0]           return_identifier, return_identifier_next;
  mode_t                mode_reg, mode_reg_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;
  logic [TRIES_W-1:0]   tries, tries_next;
  logic [7:0]           saved_function_type, saved_function_type_next;
  logic [7:0]           saved_information_number, saved_information_number_next;
  logic [7:0]           saved_value, saved_value_next;
  logic                 ready_flag, ready_flag_next;
  err_t                 error_reg, error_reg_next;
  logic                 waiting_flag, waiting_flag_next;
  logic                 resend_flag, resend_flag_next;
  logic [7:0]           remote_reg, remote_reg_next;

  logic [TRIES_W:0]     tries_inc;
  logic                 tries_over;
  logic [ELAPSED_W:0]   acc_sum;
  logic [ELAPSED_W-1:0] acc;
  logic                 resp_match;
  err_t                 ack_err;

  assign tries_inc  = {1'b0, tries} + (TRIES_W+1)'(1);
  assign tries_over = tries_inc > (TRIES_W+1)'(MAX_TRIES);
  assign acc_sum    = {1'b0, elapsed} + (ELAPSED_W+1)'(tick_step);
  assign resp_match = (in_word.resp_function_type == saved_function_type) &&
                      (in_word.resp_information_number == saved_information_number);

  always_comb begin
    if (mode_reg == MODE_IDLE) begin
      acc = '0;
    end else if (acc_sum[ELAPSED_W]) begin
      acc = ELAPSED_MAX;
    end else begin
      acc = acc_sum[ELAPSED_W-1:0];
    end
  end

  always_comb begin
    if (return_identifier != in_word.resp_return_info) begin
      ack_err = ERR_IDENT;
    end else if (saved_value != in_word.resp_value) begin
      ack_err = ERR_VALUE;
    end else begin
      ack_err = ERR_NONE;
    end
  end

  always_comb begin
    frame_count_bit_next          = frame_count_bit;
    return_identifier_next        = return_identifier;
    mode_reg_next                 = mode_reg;
    elapsed_next                  = elapsed;
    tries_next                    = tries;
    saved_function_type_next      = saved_function_type;
    saved_information_number_next = saved_information_number;
    saved_value_next              = saved_value;
    ready_flag_next               = ready_flag;
    error_reg_next                = error_reg;
    waiting_flag_next             = waiting_flag;
    resend_flag_next              = resend_flag;
    remote_reg_next               = remote_reg;
    case (in_word.operation)
      OP_SEND: begin
        if (!in_word.is_repeat) begin
          frame_count_bit_next   = ~frame_count_bit;
          return_identifier_next = return_identifier + 8'd1;
        end
        saved_function_type_next      = in_word.function_type;
        saved_information_number_next = in_word.information_number;
        saved_value_next              = in_word.command_value;
        resend_flag_next              = 1'b0;
        waiting_flag_next             = 1'b1;
        ready_flag_next               = 1'b0;
        error_reg_next                = ERR_NONE;
        mode_reg_next                 = MODE_WAIT;
      end
      OP_TICK: begin
        elapsed_next = acc;
        if (acc > ELAPSED_W'(timeout_limit)) begin
          elapsed_next = '0;
          if (tries_over) begin
            tries_next     = '0;
            error_reg_next = ERR_TIMEOUT;
            mode_reg_next  = MODE_IDLE;
          end else begin
            tries_next       = tries_inc[TRIES_W-1:0];
            resend_flag_next = 1'b1;
            mode_reg_next    = MODE_REPEAT;
          end
        end
      end
      OP_RESP: begin
        if (resp_match) begin
          waiting_flag_next = 1'b0;
          case (in_word.resp_cause)
            CAUSE_NAK: begin
              mode_reg_next   = MODE_IDLE;
              error_reg_next  = ERR_NAK;
              ready_flag_next = 1'b1;
              tries_next      = '0;
            end
            CAUSE_ACK: begin
              elapsed_next = '0;
              if (ack_err == ERR_NONE) begin
                error_reg_next  = ERR_NONE;
                mode_reg_next   = MODE_IDLE;
                tries_next      = '0;
                ready_flag_next = 1'b1;
              end else if (tries_over) begin
                tries_next      = '0;
                error_reg_next  = ack_err;
                mode_reg_next   = MODE_IDLE;
                ready_flag_next = 1'b1;
              end else begin
                tries_next       = tries_inc[TRIES_W-1:0];
                resend_flag_next = 1'b1;
                mode_reg_next    = MODE_REPEAT;
              end
            end
            CAUSE_REMOTE: begin
              remote_reg_next = in_word.resp_value;
              error_reg_next  = ERR_NONE;
              mode_reg_next   = MODE_IDLE;
              elapsed_next    = '0;
              tries_next      = '0;
              ready_flag_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count_bit          <= 1'b0;
      return_identifier        <= '0;
      mode_reg                 <= MODE_IDLE;
      elapsed                  <= '0;
      tries                    <= '0;
      saved_function_type      <= '0;
      saved_information_number <= '0;
      saved_value              <= '0;
      ready_flag               <= 1'b0;
      error_reg                <= ERR_NONE;
      waiting_flag             <= 1'b0;
      resend_flag              <= 1'b0;
      remote_reg               <= '0;
    end else if (accept) begin
      frame_count_bit          <= frame_count_bit_next;
      return_identifier        <= return_identifier_next;
      mode_reg                 <= mode_reg_next;
      elapsed                  <= elapsed_next;
      tries                    <= tries_next;
      saved_function_type      <= saved_function_type_next;
      saved_information_number <= saved_information_number_next;
      saved_value              <= saved_value_next;
      ready_flag               <= ready_flag_next;
      error_reg                <= error_reg_next;
      waiting_flag             <= waiting_flag_next;
      resend_flag              <= resend_flag_next;
      remote_reg               <= remote_reg_next;
    end
  end

  // status after this word, plus the frame built from the updated counters
  always_comb begin
    load_word.is_send        = (in_word.operation == OP_SEND);
    load_word.status.mode    = mode_reg_next;
    load_word.status.ready   = ready_flag_next;
    load_word.status.error   = error_reg_next;
    load_word.status.resend  = resend_flag_next;
    load_word.status.remote  = remote_reg_next;
    load_word.status.waiting = waiting_flag_next;
    load_word.frame.fcb      = frame_count_bit_next;
    load_word.frame.addr     = in_word.station_address;
    load_word.frame.ftype    = in_word.function_type;
    load_word.frame.inum     = in_word.information_number;
    load_word.frame.value    = in_word.command_value;
    load_word.frame.rid      = return_identifier_next;
    load_word.frame.sum      = ctrl_byte(frame_count_bit_next) + in_word.station_address
                               + FR_TYPE_ID + FR_VSQ + FR_COT + in_word.station_address
                               + in_word.function_type + in_word.information_number
                               + in_word.command_value + return_identifier_next;
  end

`ifndef SYNTHESIS
  a_tries_bound: assert property (@(posedge clk) disable iff (rst)
    32'(tries) <= MAX_TRIES)
    else $error("try count beyond limit");

  a_send_state: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.operation == OP_SEND |=>
      mode_reg == MODE_WAIT && error_reg == ERR_NONE && waiting_flag && !ready_flag)
    else $error("send did not arm the transaction");

  a_resp_nomatch: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.operation == OP_RESP && !resp_match |=>
      $stable(mode_reg) && $stable(error_reg) && $stable(tries) && $stable(waiting_flag))
    else $error("unmatched response changed state");
`endif

endmodule

// File: rtl/gct_out.sv
// gct_out: output register and frame sequencer, one result word per cycle while out_ready is high.
// Depends on gct_pkg.
`timescale 1ns / 1ps

module gct_out
  import gct_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  load_t load_word,
  output logic  free,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_word
);

  load_t                  held;
  logic [FRAME_IDX_W-1:0] idx;
  logic                   last;

  assign last = !held.is_send || (idx == FRAME_IDX_W'(FRAME_LEN - 1));
  assign free = !out_valid || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (out_valid && out_ready) begin
      if (last) begin
        out_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + FRAME_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_word;
    end
  end

  always_comb begin
    out_word.frame_byte        = held.is_send ? frame_byte_at(idx, held.frame) : 8'd0;
    out_word.is_frame          = held.is_send;
    out_word.last              = last;
    out_word.mode              = held.status.mode;
    out_word.ready_res         = held.status.ready;
    out_word.error_code        = held.status.error;
    out_word.resend_request    = held.status.resend;
    out_word.remote_value      = held.status.remote;
    out_word.awaiting_response = held.status.waiting;
  end

`ifndef SYNTHESIS
  a_no_load_mid_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !free)
    else $error("new word taken in the middle of a frame");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> idx == $past(idx) + FRAME_IDX_W'(1))
    else $error("frame index did not advance");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last && !load |=> !out_valid)
    else $error("output still valid after final word");
`endif

endmodule

// File: rtl/general_command_transaction.sv
// general_command_transaction: top level of the general-command master.
// Depends on gct_pkg, gct_core and gct_out.
`timescale 1ns / 1ps
//
// Usage
//   Input channel in_valid/in_ready/in_word carries one command word: a send,
//   a time tick or a received response. Output channel out_valid/out_ready/
//   out_word carries result words; the last one of each input has last set.
//   A send gives 16 result words (the long frame, one byte per word), a tick,
//   a response or an unused code gives one status word.
//   The first result word is valid the cycle after acceptance.
//   Tick and response words go at one per cycle while out_ready is high; a send
//   holds the input until its last frame byte is taken. A new word is
//   taken in the same cycle as the final result word of the previous one.
//   A stalled receiver (out_ready low) holds the current result word and, once
//   its last word is pending, the input too.
//   cfg_wen/cfg_index/cfg_data write timeout_limit (0) or tick_step (1), by cfg_index;
//   write only while no result is pending.
//   Reset (rst, synchronous) clears the transaction state, empties the output
//   and restores timeout_limit 1000 and tick_step 10.

module general_command_transaction
  import gct_pkg::*;
#(
  parameter int MAX_TRIES = MAX_TRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_word,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [LIMIT_W-1:0] timeout_limit;
  logic [STEP_W-1:0]  tick_step;
  logic               accept;
  load_t              load_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_LIMIT_RST;
      tick_step     <= TICK_STEP_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data[LIMIT_W-1:0];
        REG_TICK_STEP:     tick_step     <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  gct_core #(
    .MAX_TRIES(MAX_TRIES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .timeout_limit(timeout_limit),
    .tick_step    (tick_step),
    .accept       (accept),
    .in_word      (in_word),
    .load_word    (load_word)
  );

  gct_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .load_word(load_word),
    .free     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule

// File: bench/tb.sv
// tb: self-checking bench for general_command_transaction, the general-command master.
// Predicts frame and status words from its own transaction model; depends on gct_pkg.
`timescale 1ns / 1ps

module tb;
  import gct_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [7:0] CAUSE_OTHER = 8'd7;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_t                    in_word;
  logic                   out_valid;
  logic                   out_ready;
  out_t                   out_word;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  general_command_transaction dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted transaction state
  logic       fcb_q;
  logic [7:0] rid_q;
  mode_t      mode_q;
  int         elapsed_q;
  int         tries_q;
  logic [7:0] saved_ft;
  logic [7:0] saved_in;
  logic [7:0] saved_val;
  logic       ready_q;
  err_t       err_q;
  logic       waiting_q;
  logic       resend_q;
  logic [7:0] remote_q;
  int         limit_q;
  int         step_q;

  out_t due_words[$];

  int send_gap_pct;
  int stall_pct;
  int items_taken;
  int words_checked;
  int frames_sent;
  int fail_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_words
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t: word %0h expected none got one", $time, out_word);
      end else begin
        want = due_words.pop_front();
        check_field("frame_byte", want.frame_byte, out_word.frame_byte);
        check_field("is_frame", 8'(want.is_frame), 8'(out_word.is_frame));
        check_field("last", 8'(want.last), 8'(out_word.last));
        check_field("mode", 8'(want.mode), 8'(out_word.mode));
        check_field("ready_res", 8'(want.ready_res), 8'(out_word.ready_res));
        check_field("error_code", 8'(want.error_code), 8'(out_word.error_code));
        check_field("resend_request", 8'(want.resend_request),
                    8'(out_word.resend_request));
        check_field("remote_value", want.remote_value, out_word.remote_value);
        check_field("awaiting_response", 8'(want.awaiting_response),
                    8'(out_word.awaiting_response));
        words_checked++;
      end
    end
  end

  task automatic reset_state();
    fcb_q     = 1'b0;
    rid_q     = 8'd0;
    mode_q    = MODE_IDLE;
    elapsed_q = 0;
    tries_q   = 0;
    saved_ft  = 8'd0;
    saved_in  = 8'd0;
    saved_val = 8'd0;
    ready_q   = 1'b0;
    err_q     = ERR_NONE;
    waiting_q = 1'b0;
    resend_q  = 1'b0;
    remote_q  = 8'd0;
    limit_q   = int'(TIMEOUT_LIMIT_RST);
    step_q    = int'(TICK_STEP_RST);
  endtask

  function automatic out_t status_word(input logic [7:0] b, input logic is_fr, input logic lst);
    out_t o;
    o.frame_byte        = b;
    o.is_frame          = is_fr;
    o.last              = lst;
    o.mode              = mode_q;
    o.ready_res         = ready_q;
    o.error_code        = err_q;
    o.resend_request    = resend_q;
    o.remote_value      = remote_q;
    o.awaiting_response = waiting_q;
    return o;
  endfunction

  // one more failed attempt; 1 once the retry budget is spent
  function automatic bit spend_try();
    tries_q++;
    if (tries_q > MAX_TRIES_DEF) begin
      tries_q = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic close_ok();
    err_q     = ERR_NONE;
    mode_q    = MODE_IDLE;
    elapsed_q = 0;
    tries_q   = 0;
    ready_q   = 1'b1;
  endtask

  task automatic track_transaction(input in_t w);
    logic [7:0] fr[16];
    logic [7:0] sum;
    err_t       bad;
    if (w.operation == OP_SEND) begin
      if (!w.is_repeat) begin
        fcb_q = ~fcb_q;
        rid_q = rid_q + 8'd1;
      end
      saved_ft  = w.function_type;
      saved_in  = w.information_number;
      saved_val = w.command_value;
      fr[0]  = FR_START;
      fr[1]  = FR_LEN;
      fr[2]  = FR_LEN;
      fr[3]  = FR_START;
      fr[4]  = FR_CTRL + {2'b00, fcb_q, 5'b00000};
      fr[5]  = w.station_address;
      fr[6]  = FR_TYPE_ID;
      fr[7]  = FR_VSQ;
      fr[8]  = FR_COT;
      fr[9]  = w.station_address;
      fr[10] = saved_ft;
      fr[11] = saved_in;
      fr[12] = saved_val;
      fr[13] = rid_q;
      sum = 8'd0;
      for (int i = 4; i < 14; i++)
        sum = sum + fr[i];
      fr[14] = sum;
      fr[15] = FR_END;
      resend_q  = 1'b0;
      waiting_q = 1'b1;
      ready_q   = 1'b0;
      err_q     = ERR_NONE;
      mode_q    = MODE_WAIT;
      for (int i = 0; i < 16; i++)
        due_words.push_back(status_word(fr[i], 1'b1, i == 15));
      frames_sent++;
    end else begin
      if (w.operation == OP_TICK) begin
        if (mode_q != MODE_IDLE) begin
          elapsed_q += step_q;
          if (elapsed_q > int'(ELAPSED_MAX))
            elapsed_q = int'(ELAPSED_MAX);
        end else begin
          elapsed_q = 0;
        end
        if (elapsed_q > limit_q) begin
          elapsed_q = 0;
          if (spend_try()) begin
            err_q  = ERR_TIMEOUT;
            mode_q = MODE_IDLE;
          end else begin
            resend_q = 1'b1;
            mode_q   = MODE_REPEAT;
          end
        end
      end else if (w.operation == OP_RESP && w.resp_function_type == saved_ft &&
                   w.resp_information_number == saved_in) begin
        waiting_q = 1'b0;
        if (w.resp_cause == CAUSE_NAK) begin
          mode_q  = MODE_IDLE;
          err_q   = ERR_NAK;
          ready_q = 1'b1;
          tries_q = 0;
        end else if (w.resp_cause == CAUSE_ACK) begin
          bad = ERR_NONE;
          if (w.resp_value != saved_val)
            bad = ERR_VALUE;
          if (w.resp_return_info != rid_q)
            bad = ERR_IDENT;
          if (bad == ERR_NONE) begin
            close_ok();
          end else if (spend_try()) begin
            err_q     = bad;
            mode_q    = MODE_IDLE;
            elapsed_q = 0;
            ready_q   = 1'b1;
          end else begin
            resend_q  = 1'b1;
            elapsed_q = 0;
            mode_q    = MODE_REPEAT;
          end
        end else if (w.resp_cause == CAUSE_REMOTE) begin
          remote_q = w.resp_value;
          close_ok();
        end
      end
      due_words.push_back(status_word(8'd0, 1'b0, 1'b1));
    end
  endtask

  task automatic send_word(input in_t w);
    if (send_gap_pct != 0)
      while ($urandom_range(0, 99) < send_gap_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_taken++;
    track_transaction(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_TIMEOUT_LIMIT)
      limit_q = int'(data);
    else
      step_q = int'(data[STEP_W-1:0]);
    @(posedge clk);
  endtask

  task automatic set_timing(input int lim, input int stp);
    wait_idle();
    write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'(lim));
    write_reg(REG_TICK_STEP, CFG_DATA_W'(stp));
  endtask

  function automatic in_t random_word(input logic [1:0] op);
    logic [95:0] bits;
    in_t w;
    bits = {$urandom, $urandom, $urandom};
    w = bits[$bits(in_t)-1:0];
    w.operation = op;
    return w;
  endfunction

  // response that matches the stored command and echoes it correctly
  function automatic in_t reply_word(input logic [7:0] cause);
    in_t w;
    w = random_word(OP_RESP);
    w.resp_cause              = cause;
    w.resp_function_type      = saved_ft;
    w.resp_information_number = saved_in;
    w.resp_value              = saved_val;
    w.resp_return_info        = rid_q;
    return w;
  endfunction

  task automatic test_status_words();
    in_t w;
    send_word(random_word(OP_TICK));
    send_word(random_word(OP_UNUSED));
    // remote operation with no command pending
    w = reply_word(CAUSE_REMOTE);
    w.resp_value = 8'hA5;
    send_word(w);
  endtask

  task automatic test_frame_layout();
    in_t w;
    w = '0;
    w.operation = OP_SEND;
    send_word(w);
    w = '1;
    w.operation = OP_SEND;
    send_word(w);
    w = random_word(OP_SEND);
    w.is_repeat = 1'b0;
    w.command_value = 8'd2;
    send_word(w);
  endtask

  task automatic test_response_causes();
    in_t cmd;
    in_t w;
    send_word(reply_word(CAUSE_ACK));
    cmd = random_word(OP_SEND);
    cmd.is_repeat = 1'b0;
    send_word(cmd);
    w = reply_word(CAUSE_ACK);
    w.resp_function_type = ~saved_ft;
    send_word(w);
    send_word(reply_word(CAUSE_OTHER));
    send_word(reply_word(CAUSE_NAK));
    cmd = random_word(OP_SEND);
    cmd.is_repeat = 1'b0;
    cmd.command_value = 8'd1;
    send_word(cmd);
    w = reply_word(CAUSE_ACK);
    w.resp_value = ~saved_val;
    send_word(w);
    cmd.is_repeat = 1'b1;
    send_word(cmd);
    // both echoes wrong: identifier mismatch wins
    w = reply_word(CAUSE_ACK);
    w.resp_value = ~saved_val;
    w.resp_return_info = ~rid_q;
    send_word(w);
    send_word(cmd);
    w = reply_word(CAUSE_ACK);
    w.resp_return_info = ~rid_q;
    send_word(w);
    send_word(cmd);
    w = reply_word(CAUSE_ACK);
    w.resp_value = ~saved_val;
    send_word(w);
  endtask

  task automatic test_timeout_retries();
    in_t cmd;
    set_timing(0, 1);
    cmd = random_word(OP_SEND);
    cmd.is_repeat = 1'b0;
    send_word(cmd);
    repeat (5) send_word(random_word(OP_TICK));
  endtask

  task automatic run_transaction();
    in_t cmd;
    in_t w;
    int  steps;
    int  pick;
    int  n;
    cmd = random_word(OP_SEND);
    cmd.is_repeat = 1'b0;
    if ($urandom_range(0, 3) != 0)
      cmd.command_value = 8'($urandom_range(1, 2));
    send_word(cmd);
    steps = 0;
    while (mode_q != MODE_IDLE && steps < 20) begin
      steps++;
      pick = $urandom_range(0, 99);
      if (mode_q == MODE_REPEAT) begin
        cmd.is_repeat = ($urandom_range(0, 9) != 0);
        send_word(cmd);
      end else if (pick < 30) begin
        send_word(reply_word(CAUSE_ACK));
      end else if (pick < 42) begin
        w = reply_word(CAUSE_ACK);
        w.resp_value = saved_val ^ 8'($urandom_range(1, 255));
        send_word(w);
      end else if (pick < 52) begin
        w = reply_word(CAUSE_ACK);
        w.resp_return_info = rid_q ^ 8'($urandom_range(1, 255));
        send_word(w);
      end else if (pick < 60) begin
        send_word(reply_word(CAUSE_NAK));
      end else if (pick < 68) begin
        send_word(reply_word(CAUSE_REMOTE));
      end else if (pick < 76) begin
        w = reply_word(8'($urandom));
        w.resp_information_number = saved_in ^ 8'($urandom_range(1, 255));
        send_word(w);
      end else begin
        n = 0;
        while (mode_q == MODE_WAIT && n < 80) begin
          send_word(random_word(OP_TICK));
          n++;
        end
      end
    end
  endtask

  task automatic test_random_traffic(input int goal, input int gap, input int stall,
                                     input int lim, input int stp);
    int target;
    int pick;
    set_timing(lim, stp);
    send_gap_pct = gap;
    stall_pct    = stall;
    target = items_taken + goal;
    while (items_taken < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)
        send_word(random_word(2'($urandom_range(0, 3))));
      else if (pick < 12)
        wait_idle();
      else
        run_transaction();
    end
  endtask

  // new sends until the return identifier rolls over, then acknowledge
  task automatic test_identifier_wrap();
    in_t cmd;
    send_gap_pct = 15;
    stall_pct    = 15;
    do begin
      cmd = random_word(OP_SEND);
      cmd.is_repeat = 1'b0;
      send_word(cmd);
    end while (rid_q != 8'd0);
    send_word(reply_word(CAUSE_ACK));
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_word      <= '0;
    cfg_wen      <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    send_gap_pct = 0;
    stall_pct    = 0;
    items_taken  = 0;
    words_checked = 0;
    frames_sent  = 0;
    fail_count   = 0;
    reset_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_status_words();
    test_frame_layout();
    test_response_causes();
    test_timeout_retries();
    test_random_traffic(70, 0, 0, 40, 10);
    test_random_traffic(70, 48, 0, 0, 1);
    test_random_traffic(70, 0, 48, 65535, 1000);
    test_random_traffic(70, 15, 15, 25, 7);
    test_identifier_wrap();

    wait_idle();
    repeat (16) @(posedge clk);
    $display("Ran %0d input words (%0d frames) under four idle/stall mixes and five timeouts;",
             items_taken, frames_sent);
    $display("%0d result words checked, return identifier taken through its wrap.",
             words_checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
